@@ rtl/bde_pkg.sv @@
// Shared types and constants of the B-spline de Boor evaluator.
// No dependencies; every module of the block imports this package.
package bde_pkg;

  localparam int MaxPoints = 64;
  localparam int PtIdxW    = 6;
  localparam int DegW      = 3;
  localparam int CntW      = 7;
  localparam int ResW      = 10;
  localparam int CoordW    = 16;
  localparam int QsW       = 17;
  localparam int DivNW     = 31;
  localparam int DivDW     = 14;
  localparam int DivQW     = 17;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } opcode_e;

  typedef struct packed {
    logic [DegW-1:0] degree;
    logic [CntW-1:0] point_count;
    logic [ResW-1:0] resolution;
  } cfg_t;

  // One classified item as it travels from front to back.
  typedef struct packed {
    opcode_e                   opcode;
    logic [PtIdxW-1:0]         point_index;
    logic signed [CoordW-1:0]  point_x;
    logic signed [CoordW-1:0]  point_y;
    logic [QsW-1:0]            qs;       // sample times segment count
    logic                      err;
    logic                      endp;     // sample sits on the last knot
  } item_t;

endpackage

@@ rtl/bde_front.sv @@
// Front end: classifies an incoming item and precomputes q times segments.
// Depends on bde_pkg.
module bde_front import bde_pkg::*; (
  input  cfg_t                     cfg_i,
  input  opcode_e                  opcode_i,
  input  logic [PtIdxW-1:0]        point_index_i,
  input  logic signed [CoordW-1:0] point_x_i,
  input  logic signed [CoordW-1:0] point_y_i,
  input  logic [ResW-1:0]          sample_index_i,
  output item_t                    item_o
);

  logic [CntW-1:0] seg;
  logic            err;

  assign seg = CntW'(cfg_i.point_count - {4'b0, cfg_i.degree});
  assign err = (cfg_i.resolution == '0) || (sample_index_i > cfg_i.resolution) ||
               (cfg_i.point_count > CntW'(MaxPoints)) ||
               (cfg_i.point_count < ({4'b0, cfg_i.degree} + 7'd1));

  always_comb begin
    item_o.opcode      = opcode_i;
    item_o.point_index = point_index_i;
    item_o.point_x     = point_x_i;
    item_o.point_y     = point_y_i;
    item_o.qs          = QsW'({7'b0, sample_index_i} * {10'b0, seg});
    item_o.err         = err;
    item_o.endp        = (sample_index_i == cfg_i.resolution);
  end

endmodule

@@ rtl/bde_queue.sv @@
// Two-entry queue of classified items between front and back.
// Depends on bde_pkg.
module bde_queue import bde_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_valid_i,
  output logic  wr_ready_o,
  input  item_t wr_item_i,
  output logic  rd_valid_o,
  input  logic  rd_pop_i,
  output item_t rd_item_o
);

  item_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push;

  assign wr_ready_o = (count_q != 2'd2);
  assign rd_valid_o = (count_q != 2'd0);
  assign rd_item_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= wr_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (rd_pop_i) rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, push} - {1'b0, rd_pop_i};
    end
  end

endmodule

@@ rtl/bde_div.sv @@
// Two-lane restoring divider with a shared divisor, one quotient bit a cycle.
// Depends on bde_pkg. Needs numerator below divisor times 2^17.
module bde_div import bde_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DivNW-1:0] num0_i,
  input  logic [DivNW-1:0] num1_i,
  input  logic [DivDW-1:0] den_i,
  output logic             done_o,
  output logic [DivQW-1:0] quo0_o,
  output logic [DivQW-1:0] quo1_o
);

  logic [DivDW-1:0] rem0_q, rem1_q, den_q;
  logic [DivQW-1:0] sh0_q, sh1_q;
  logic [4:0]       cnt_q;
  logic             done_q;
  logic [DivDW:0]   t0, t1;
  logic             ge0, ge1;

  assign t0  = {rem0_q, sh0_q[DivQW-1]};
  assign t1  = {rem1_q, sh1_q[DivQW-1]};
  assign ge0 = (t0 >= {1'b0, den_q});
  assign ge1 = (t1 >= {1'b0, den_q});

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem0_q <= num0_i[DivNW-1:DivQW];
      rem1_q <= num1_i[DivNW-1:DivQW];
      sh0_q  <= num0_i[DivQW-1:0];
      sh1_q  <= num1_i[DivQW-1:0];
      den_q  <= den_i;
    end else if (cnt_q != 5'd0) begin
      rem0_q <= ge0 ? DivDW'(t0 - {1'b0, den_q}) : t0[DivDW-1:0];
      rem1_q <= ge1 ? DivDW'(t1 - {1'b0, den_q}) : t1[DivDW-1:0];
      sh0_q  <= {sh0_q[DivQW-2:0], ge0};
      sh1_q  <= {sh1_q[DivQW-2:0], ge1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 5'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == 5'd1);
      if (start_i) cnt_q <= 5'(DivQW);
      else if (cnt_q != 5'd0) cnt_q <= cnt_q - 5'd1;
    end
  end

  assign done_o = done_q;
  assign quo0_o = sh0_q;
  assign quo1_o = sh1_q;

endmodule

@@ rtl/bde_back.sv @@
// Back end: point table, blend row and the de Boor sequencer with its output register.
// Depends on bde_pkg and bde_div.
module bde_back import bde_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cfg_t                     cfg_i,
  input  logic                     q_valid_i,
  input  item_t                    q_item_i,
  output logic                     q_pop_o,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic signed [CoordW-1:0] out_x_o,
  output logic signed [CoordW-1:0] out_y_o,
  output logic                     out_err_o
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_ENDRD  = 4'd1;
  localparam logic [3:0] ST_SPAN   = 4'd2;
  localparam logic [3:0] ST_FETCH  = 4'd3;
  localparam logic [3:0] ST_FWR    = 4'd4;
  localparam logic [3:0] ST_KNOT   = 4'd5;
  localparam logic [3:0] ST_COEF   = 4'd6;
  localparam logic [3:0] ST_RDB    = 4'd7;
  localparam logic [3:0] ST_MULA   = 4'd8;
  localparam logic [3:0] ST_MULB   = 4'd9;
  localparam logic [3:0] ST_DSTART = 4'd10;
  localparam logic [3:0] ST_DIV    = 4'd11;
  localparam logic [3:0] ST_FINRD  = 4'd12;
  localparam logic [3:0] ST_FINOUT = 4'd13;

  // clamp(v - p, 0, s)
  function automatic logic [CntW-1:0] knot(input logic [7:0] v, input logic [DegW-1:0] p,
                                           input logic [CntW-1:0] s);
    logic signed [8:0] d;
    d = $signed({1'b0, v}) - $signed({6'b0, p});
    if (d < 0) return '0;
    else if (d > $signed({2'b0, s})) return s;
    else return d[CntW-1:0];
  endfunction

  logic [3:0] state_q, state_d;
  logic [PtIdxW-1:0] base_q, base_d;
  logic [DegW-1:0] cnt_q, cnt_d, j_q, j_d, k_q, k_d;
  logic [QsW-1:0] qs_q, qs_d, lor_q, lor_d;
  logic [DegW-1:0] dlt_q, dlt_d;
  logic [12:0] den_q, den_d;
  logic signed [17:0] num_q, num_d;
  logic signed [CoordW-1:0] ax_q, ay_q, bx_q, by_q;
  logic signed [30:0] pax_q, pay_q, sx_q, sy_q, pbx, pby;
  logic [12:0] w0;
  logic ok;

  logic out_valid_q, out_err_q;
  logic signed [CoordW-1:0] out_x_q, out_y_q;
  logic out_load;
  logic [31:0] out_data;
  logic out_err_d;

  logic [31:0] tbl_mem [MaxPoints];
  logic [31:0] tbl_rdata_q;
  logic [PtIdxW-1:0] tbl_raddr;
  logic tbl_we;

  logic [31:0] row_mem [8];
  logic [31:0] row_rdata_q, row_wdata;
  logic [DegW-1:0] row_raddr, row_waddr;
  logic row_we;

  logic div_start, div_done;
  logic [DivNW-1:0] div_n0, div_n1;
  logic [DivDW-1:0] div_d;
  logic [DivQW-1:0] quo0, quo1;

  logic [CntW-1:0] seg;
  logic [7:0] i_lo, i_hi;
  logic [CntW-1:0] lo, hi;

  bde_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num0_i(div_n0), .num1_i(div_n1),
    .den_i(div_d), .done_o(div_done), .quo0_o(quo0), .quo1_o(quo1)
  );

  assign seg  = CntW'(cfg_i.point_count - {4'b0, cfg_i.degree});
  assign i_lo = {2'b0, base_q} + {5'b0, j_q};
  assign i_hi = i_lo + {5'b0, cfg_i.degree} + 8'd1 - {5'b0, k_q};
  assign lo   = knot(i_lo, cfg_i.degree, seg);
  assign hi   = knot(i_hi, cfg_i.degree, seg);
  assign w0   = den_q - num_q[12:0];
  assign pbx  = bx_q * $signed({1'b0, num_q[12:0]});
  assign pby  = by_q * $signed({1'b0, num_q[12:0]});
  assign ok   = (den_q != '0) && !num_q[17] && (num_q[16:0] <= {4'b0, den_q});

  // Memories with registered read data.
  always_ff @(posedge clk_i) begin
    if (tbl_we) tbl_mem[q_item_i.point_index] <= {q_item_i.point_y, q_item_i.point_x};
    tbl_rdata_q <= tbl_mem[tbl_raddr];
    if (row_we) row_mem[row_waddr] <= row_wdata;
    row_rdata_q <= row_mem[row_raddr];
  end

  always_comb begin
    state_d   = state_q;
    base_d    = base_q;
    cnt_d     = cnt_q;
    j_d       = j_q;
    k_d       = k_q;
    qs_d      = qs_q;
    lor_d     = lor_q;
    dlt_d     = dlt_q;
    den_d     = den_q;
    num_d     = num_q;
    q_pop_o   = 1'b0;
    tbl_we    = 1'b0;
    tbl_raddr = base_q + {3'b0, cnt_q};
    row_we    = 1'b0;
    row_waddr = j_q;
    row_wdata = {ay_q, ax_q};
    row_raddr = j_q;
    div_start = 1'b0;
    div_n0    = {{(DivNW-QsW){1'b0}}, q_item_i.qs};
    div_n1    = '0;
    div_d     = {4'b0, cfg_i.resolution};
    out_load  = 1'b0;
    out_data  = '0;
    out_err_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        tbl_raddr = PtIdxW'(cfg_i.point_count - 7'd1);
        if (q_valid_i && !out_valid_q) begin
          q_pop_o = 1'b1;
          if (q_item_i.opcode == OP_LOAD) begin
            tbl_we = 1'b1;
          end else if (q_item_i.err) begin
            out_load  = 1'b1;
            out_err_d = 1'b1;
          end else if (q_item_i.endp) begin
            state_d = ST_ENDRD;
          end else begin
            qs_d      = q_item_i.qs;
            div_start = 1'b1;
            state_d   = ST_SPAN;
          end
        end
      end
      ST_ENDRD: begin
        out_load = 1'b1;
        out_data = tbl_rdata_q;
        state_d  = ST_IDLE;
      end
      ST_SPAN: begin
        if (div_done) begin
          base_d  = quo0[PtIdxW-1:0];
          cnt_d   = '0;
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: state_d = ST_FWR;
      ST_FWR: begin
        row_we    = 1'b1;
        row_waddr = cnt_q;
        row_wdata = tbl_rdata_q;
        if (cnt_q == cfg_i.degree) begin
          k_d     = 3'd1;
          j_d     = cfg_i.degree;
          state_d = (cfg_i.degree == '0) ? ST_FINRD : ST_KNOT;
        end else begin
          cnt_d   = cnt_q + 3'd1;
          state_d = ST_FETCH;
        end
      end
      ST_KNOT: begin
        lor_d     = QsW'({10'b0, lo} * {7'b0, cfg_i.resolution});
        dlt_d     = DegW'(hi - lo);
        row_raddr = j_q - 3'd1;
        state_d   = ST_COEF;
      end
      ST_COEF: begin
        den_d   = 13'({10'b0, dlt_q} * {3'b0, cfg_i.resolution});
        num_d   = $signed({1'b0, qs_q}) - $signed({1'b0, lor_q});
        state_d = ST_RDB;
      end
      ST_RDB: begin
        if (ok) begin
          state_d = ST_MULA;
        end else begin
          row_we = 1'b1;
          if (j_q > k_q) begin
            j_d = j_q - 3'd1;
            state_d = ST_KNOT;
          end else if (k_q == cfg_i.degree) begin
            state_d = ST_FINRD;
          end else begin
            k_d = k_q + 3'd1;
            j_d = cfg_i.degree;
            state_d = ST_KNOT;
          end
        end
      end
      ST_MULA:   state_d = ST_MULB;
      ST_MULB:   state_d = ST_DSTART;
      ST_DSTART: begin
        div_start = 1'b1;
        div_n0    = {sx_q[29:0], 1'b0} + {18'b0, den_q};
        div_n1    = {sy_q[29:0], 1'b0} + {18'b0, den_q};
        div_d     = {den_q, 1'b0};
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          // Quotient is the result biased by half the range: flip the sign bit.
          row_we    = 1'b1;
          row_wdata = {~quo1[CoordW-1], quo1[CoordW-2:0], ~quo0[CoordW-1], quo0[CoordW-2:0]};
          if (j_q > k_q) begin
            j_d = j_q - 3'd1;
            state_d = ST_KNOT;
          end else if (k_q == cfg_i.degree) begin
            state_d = ST_FINRD;
          end else begin
            k_d = k_q + 3'd1;
            j_d = cfg_i.degree;
            state_d = ST_KNOT;
          end
        end
      end
      ST_FINRD: begin
        row_raddr = cfg_i.degree;
        state_d   = ST_FINOUT;
      end
      ST_FINOUT: begin
        out_load = 1'b1;
        out_data = row_rdata_q;
        state_d  = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    cnt_q  <= cnt_d;
    j_q    <= j_d;
    k_q    <= k_d;
    qs_q   <= qs_d;
    lor_q  <= lor_d;
    dlt_q  <= dlt_d;
    den_q  <= den_d;
    num_q  <= num_d;
    if (state_q == ST_COEF) begin
      ax_q <= row_rdata_q[CoordW-1:0];
      ay_q <= row_rdata_q[31:CoordW];
    end
    if (state_q == ST_RDB) begin
      bx_q <= row_rdata_q[CoordW-1:0];
      by_q <= row_rdata_q[31:CoordW];
    end
    if (state_q == ST_MULA) begin
      pax_q <= ax_q * $signed({1'b0, w0});
      pay_q <= ay_q * $signed({1'b0, w0});
    end
    if (state_q == ST_MULB) begin
      sx_q <= pax_q + pbx + $signed({3'b0, den_q, 15'b0});
      sy_q <= pay_q + pby + $signed({3'b0, den_q, 15'b0});
    end
    if (out_load) begin
      out_x_q   <= out_data[CoordW-1:0];
      out_y_q   <= out_data[31:CoordW];
      out_err_q <= out_err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign out_err_o   = out_err_q;

endmodule

@@ rtl/bspline_de_boor_evaluator_unit.sv @@
// Top level of the clamped uniform B-spline evaluator (de Boor scheme).
// Depends on bde_pkg, bde_front, bde_queue, bde_back (which holds bde_div).
//
//   channel   direction  tdata / data                        tuser
//   s_axis    in         idx, x, y, sample (48 bits)          opcode
//   m_axis    out        curve_x, curve_y (32 bits)           error
//   cfg       in         cfg_index_i 2 bits, cfg_data_i 10    -
//
// A load is written from the idle state. An evaluation of degree p divides once
// for the span, fetches p+1 points and works p(p+1)/2 blends; a blend whose weight
// falls outside its range copies its left point. The 17-step shared divider runs
// once for the span and once per blend in range. An error sample is answered from
// the idle state, an end sample after a table read. Reset is asynchronous, active
// low, and restores degree 3, 4 points, resolution 100. The two-entry queue takes
// items while not full, as the back end works or a result waits on m_axis_tready.
module bspline_de_boor_evaluator_unit import bde_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // point_index, point_x, point_y, sample_index
  input  logic [0:0]  s_axis_tuser,   // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // curve_x, curve_y
  output logic [0:0]  m_axis_tuser,   // error
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [9:0]  cfg_data_i
);

  localparam logic [1:0] CFG_DEGREE = 2'd0;
  localparam logic [1:0] CFG_POINTS = 2'd1;
  localparam logic [1:0] CFG_RES    = 2'd2;

  cfg_t  cfg_q;
  item_t front_item, head_item;
  logic  q_valid, q_pop;
  logic signed [CoordW-1:0] out_x, out_y;
  logic  out_err;

  // The user must write registers only while idle (unchecked); accepted at once.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.degree      <= 3'd3;
      cfg_q.point_count <= 7'd4;
      cfg_q.resolution  <= 10'd100;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_DEGREE: cfg_q.degree      <= cfg_data_i[DegW-1:0];
        CFG_POINTS: cfg_q.point_count <= cfg_data_i[CntW-1:0];
        CFG_RES:    cfg_q.resolution  <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  bde_front u_front (
    .cfg_i          (cfg_q),
    .opcode_i       (opcode_e'(s_axis_tuser[0])),
    .point_index_i  (s_axis_tdata[5:0]),
    .point_x_i      (s_axis_tdata[21:6]),
    .point_y_i      (s_axis_tdata[37:22]),
    .sample_index_i (s_axis_tdata[47:38]),
    .item_o         (front_item)
  );

  bde_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i (s_axis_tvalid),
    .wr_ready_o (s_axis_tready),
    .wr_item_i  (front_item),
    .rd_valid_o (q_valid),
    .rd_pop_i   (q_pop),
    .rd_item_o  (head_item)
  );

  bde_back u_back (
    .clk_i, .rst_ni,
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_item_i    (head_item),
    .q_pop_o     (q_pop),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_x_o     (out_x),
    .out_y_o     (out_y),
    .out_err_o   (out_err)
  );

  assign m_axis_tdata = {out_y, out_x};
  assign m_axis_tuser = out_err;

  // An error result carries zero coordinates.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 32'd0)
    else $error("error result with nonzero coordinates");

  // The back end takes a new item only once the output register is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !m_axis_tvalid && q_valid)
    else $error("item popped while a result still waits");

  // A popped error item presents its result on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop && head_item.opcode == OP_EVAL && head_item.err |=> m_axis_tvalid)
    else $error("error item produced no result");

endmodule

@@ sim/tb_bspline_de_boor_evaluator_unit.sv @@
// Self-checking testbench for the clamped uniform B-spline evaluator.
// Depends on bde_pkg and bspline_de_boor_evaluator_unit; a scoreboard class
// predicts each curve point, and plain tasks drive the stream and register ports.
module tb_bspline_de_boor_evaluator_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import bde_pkg::*;

  localparam int unsigned CycleLimit = 3_000_000;
  localparam int          SettleCycles = 50;   // lets trailing loads retire before a register write
  localparam int          DrainCycles  = 800;  // longer than a degree 7 evaluation
  localparam logic [1:0]  RegDegree = 2'd0, RegPointCount = 2'd1, RegResolution = 2'd2;

  typedef struct {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic                     err;
  } curve_pt_t;

  // Predicts curve points in transaction order and holds them until checked.
  class curve_scoreboard;
    longint     deg, cnt, res;
    longint     ctrl_pts [MaxPoints][2];
    longint     row [8][2];
    curve_pt_t  pending_pts [$];

    function new();
      deg = 3; cnt = 4; res = 100;
      foreach (ctrl_pts[i]) begin
        ctrl_pts[i][0] = 0;
        ctrl_pts[i][1] = 0;
      end
    endfunction

    function void write_reg(logic [1:0] idx, logic [9:0] val);
      case (idx)
        RegDegree:     deg = val[DegW-1:0];
        RegPointCount: cnt = val[CntW-1:0];
        RegResolution: res = val;
        default: ;
      endcase
    endfunction

    // Scaled knot value: clamp(j - p, 0, s).
    function longint knot_at(longint j, longint p, longint s);
      longint v;
      v = j - p;
      if (v < 0) return 0;
      if (v > s) return s;
      return v;
    endfunction

    // Weighted mix of two coordinates, rounded to nearest with ties upward.
    function longint mix(longint a, longint b, longint num, longint den);
      longint sum, biased;
      sum    = a * (den - num) + b * num;
      biased = sum + 32768 * den;
      return (2 * biased + den) / (2 * den) - 32768;
    endfunction

    function curve_pt_t evaluate(longint q);
      curve_pt_t pt;
      longint s, l, i, lo, hi, num, den;
      pt = '{x: '0, y: '0, err: 1'b0};
      if (res == 0 || q > res || deg > 7 || cnt > MaxPoints || cnt < deg + 1) begin
        pt.err = 1'b1;
        return pt;
      end
      if (q == res) begin
        pt.x = ctrl_pts[cnt-1][0][CoordW-1:0];
        pt.y = ctrl_pts[cnt-1][1][CoordW-1:0];
        return pt;
      end
      s = cnt - deg;
      l = deg + (q * s) / res;
      for (int j = 0; j <= deg; j++) begin
        row[j][0] = ctrl_pts[j+l-deg][0];
        row[j][1] = ctrl_pts[j+l-deg][1];
      end
      for (int k = 1; k <= deg; k++) begin
        for (int j = deg; j >= k; j--) begin
          i   = j + l - deg;
          lo  = knot_at(i, deg, s);
          hi  = knot_at(i + deg + 1 - k, deg, s);
          den = (hi - lo) * res;
          num = q * s - lo * res;
          for (int c = 0; c < 2; c++) begin
            if (den > 0 && num >= 0 && num <= den) row[j][c] = mix(row[j-1][c], row[j][c], num, den);
            else row[j][c] = row[j-1][c];
          end
        end
      end
      pt.x = row[deg][0][CoordW-1:0];
      pt.y = row[deg][1][CoordW-1:0];
      return pt;
    endfunction

    function void note_input(opcode_e op, logic [5:0] idx, logic signed [15:0] px,
                             logic signed [15:0] py, logic [9:0] q);
      if (op == OP_LOAD) begin
        ctrl_pts[idx][0] = px;
        ctrl_pts[idx][1] = py;
      end else begin
        pending_pts = {pending_pts, evaluate(q)};
      end
    endfunction

    // Compare one delivered point against the oldest prediction.
    function bit check_result(curve_pt_t got, output string why);
      curve_pt_t exp_pt;
      why = "";
      if (pending_pts.size() == 0) begin
        why = "result with no evaluation outstanding";
        return 0;
      end
      exp_pt = pending_pts.pop_front();
      if (got.x !== exp_pt.x) why = {why, $sformatf(" curve_x %0d/%0d", got.x, exp_pt.x)};
      if (got.y !== exp_pt.y) why = {why, $sformatf(" curve_y %0d/%0d", got.y, exp_pt.y)};
      if (got.err !== exp_pt.err) why = {why, $sformatf(" error %0b/%0b", got.err, exp_pt.err)};
      return why == "";
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [9:0]  cfg_data_i = '0;

  curve_scoreboard sb = new();
  int unsigned     mismatches = 0;
  int unsigned     cycle_cnt = 0;
  bit              sink_stalls = 1'b1;  // cleared for stretches with a free-running sink
  bit              src_gaps = 1'b1;
  int              sink_hold = 0;

  bspline_de_boor_evaluator_unit dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic report(string what);
    $display("MISMATCH at cycle %0d:%s", cycle_cnt, what);
    mismatches++;
  endtask

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("Some tests failed");
      $finish;
    end
  end

  // Sink: hold tready low for random stalls, mostly short, now and then long.
  always @(posedge clk_i) begin
    int roll;
    roll = $urandom_range(0, 99);
    if (!sink_stalls) begin
      m_axis_tready <= 1'b1;
    end else if (sink_hold > 0) begin
      sink_hold     <= sink_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (roll < 60) begin
      m_axis_tready <= 1'b1;
    end else if (roll < 95) begin
      m_axis_tready <= 1'b0;
      sink_hold     <= $urandom_range(0, 2);
    end else begin
      m_axis_tready <= 1'b0;
      sink_hold     <= $urandom_range(20, 80);
    end
  end

  // Check every transaction on the output stream.
  always @(posedge clk_i) begin
    curve_pt_t got;
    string     why;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.x   = m_axis_tdata[15:0];
      got.y   = m_axis_tdata[31:16];
      got.err = m_axis_tuser[0];
      if (!sb.check_result(got, why)) report(why);
    end
  end

  task automatic idle_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (!src_gaps || roll < 70) return;
    s_axis_tvalid <= 1'b0;
    if (roll < 95) repeat ($urandom_range(1, 3)) @(posedge clk_i);
    else repeat ($urandom_range(20, 60)) @(posedge clk_i);
  endtask

  // Present one item and hold it until the block takes it. tready only moves at
  // the rising edge, so its value at the falling edge is what the next edge sees.
  task automatic send_item(opcode_e op, logic [5:0] idx, logic [15:0] px,
                           logic [15:0] py, logic [9:0] q);
    bit rdy;
    idle_gap();
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {q, py, px, idx};
    do begin
      @(negedge clk_i);
      rdy = s_axis_tready;
      @(posedge clk_i);
    end while (!rdy);
    sb.note_input(op, idx, px, py, q);
  endtask

  task automatic load_point(int idx, logic [15:0] px, logic [15:0] py);
    send_item(OP_LOAD, idx[5:0], px, py, 10'($urandom));
  endtask

  task automatic eval_sample(int q);
    send_item(OP_EVAL, 6'($urandom), 16'($urandom), 16'($urandom), q[9:0]);
  endtask

  // Drain outstanding results and let trailing loads retire before a register write.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_pts.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Hold valid high across back-to-back writes; the caller drops it after the last.
  task automatic write_reg(logic [1:0] idx, logic [9:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
  endtask

  task automatic set_config(int p, int n, int r);
    wait_idle();
    write_reg(RegDegree, p[9:0]);
    write_reg(RegPointCount, n[9:0]);
    write_reg(RegResolution, r[9:0]);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly in-range samples with the ends hit often; some loads reshape the curve.
  task automatic random_phase(int items);
    int roll;
    src_gaps    = $urandom_range(0, 3) != 0;
    sink_stalls = $urandom_range(0, 3) != 0;
    for (int i = 0; i < items; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 25) load_point($urandom_range(0, MaxPoints - 1), 16'($urandom), 16'($urandom));
      else if (roll < 30) eval_sample(sb.res);
      else if (roll < 33) eval_sample(0);
      else if (roll < 88) eval_sample($urandom_range(0, sb.res));
      else eval_sample($urandom_range(0, 1023));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill the whole table first so no evaluation reads an unwritten slot.
    for (int i = 0; i < MaxPoints; i++) load_point(i, 16'($urandom), 16'($urandom));

    // Directed: coordinate extremes, span edges, end sample and past-end samples.
    load_point(0, 16'h8000, 16'h7fff);
    load_point(1, 16'h7fff, 16'h8000);
    load_point(2, 16'h8000, 16'h8000);
    load_point(3, 16'h7fff, 16'h7fff);
    eval_sample(0);
    eval_sample(1);
    eval_sample(25);
    eval_sample(50);
    eval_sample(99);
    eval_sample(100);
    eval_sample(101);
    eval_sample(1023);

    set_config(1, 2, 1);        // smallest legal setting at degree 1
    eval_sample(0);
    eval_sample(1);
    eval_sample(2);
    set_config(0, 5, 37);       // degree zero returns the span point
    eval_sample(0);
    eval_sample(36);
    eval_sample(37);
    set_config(3, 3, 100);      // too few points
    eval_sample(10);
    set_config(2, 100, 100);    // more points than the table holds
    eval_sample(10);
    set_config(2, 10, 0);       // zero resolution
    eval_sample(0);

    set_config(3, 4, 100);   random_phase(60);
    set_config(1, 2, 1);     random_phase(40);
    set_config(7, 64, 1023); random_phase(40);
    set_config(0, 9, 37);    random_phase(40);
    set_config(2, 10, 7);    random_phase(50);
    set_config(7, 8, 3);     random_phase(40);
    set_config(5, 64, 500);  random_phase(40);
    set_config(4, 4, 20);    random_phase(30);
    set_config(2, 127, 0);   random_phase(20);
    set_config($urandom_range(1, 7), $urandom_range(8, 64), $urandom_range(1, 1023));
    random_phase(60);
    set_config(3, $urandom_range(4, 16), $urandom_range(1, 64));
    random_phase(60);

    s_axis_tvalid <= 1'b0;
    while (sb.pending_pts.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.pending_pts.size() != 0) report(" evaluations left without a result");
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/bde_pkg.sv
rtl/bde_front.sv
rtl/bde_queue.sv
rtl/bde_div.sv
rtl/bde_back.sv
rtl/bspline_de_boor_evaluator_unit.sv
sim/tb_bspline_de_boor_evaluator_unit.sv
